@@ rtl/core/uartrb_pkg.sv @@
// ----------------------------------------------------------------------------
// uartrb_pkg
// Types and constants shared by the serial port ring buffer unit.
// ----------------------------------------------------------------------------
package uartrb_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEVEL_W = 5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EVENT = 2'd2
  } uartrb_op_t;

  typedef struct packed {
    logic               write_accepted;
    logic               read_valid;
    logic               send_valid;
    logic               rx_dropped;
    logic               tx_irq_on;
    logic               rx_available;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } uartrb_status_t;

endpackage

@@ rtl/core/uart_tx_rx_ring_buffers_unit.sv @@
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers_unit
// Transmit and receive byte rings between software and a serial port.
// ----------------------------------------------------------------------------
// Each transaction (software write, software read or port interrupt event) is
// taken when in_valid and in_ready are high, and its result passes through
// the pending register into the output register. A new transaction can be
// taken every cycle while the output side keeps up; the rate is set by the
// single read port of each ring memory, which is read at the take index on
// the accepting edge, with pointers, fill counts and the transmit interrupt
// enable updated on that same edge. Ring memories need no clearing after
// reset: the fill counts mask every entry that has not been written.
module uart_tx_rx_ring_buffers_unit
  import uartrb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [BYTE_W-1:0]  in_write_byte,
  input  logic               in_rx_ready,
  input  logic [BYTE_W-1:0]  in_rx_byte,
  input  logic               in_tx_empty,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_write_accepted,
  output logic               out_read_valid,
  output logic [BYTE_W-1:0]  out_read_byte,
  output logic               out_send_valid,
  output logic [BYTE_W-1:0]  out_send_byte,
  output logic               out_rx_dropped,
  output logic               out_tx_irq_on,
  output logic               out_rx_available,
  output logic [LEVEL_W-1:0] out_tx_level,
  output logic [LEVEL_W-1:0] out_rx_level
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(RING_DEPTH);

  logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
  logic [BYTE_W-1:0] rx_mem [RING_DEPTH];

  logic [AW-1:0] tx_put_r, tx_put_nxt, tx_take_r, tx_take_nxt;
  logic [AW-1:0] rx_put_r, rx_put_nxt, rx_take_r, rx_take_nxt;
  logic [FW-1:0] tx_fill_r, tx_fill_nxt, rx_fill_r, rx_fill_nxt;
  logic          tx_irq_r, tx_irq_nxt;

  logic          tx_wr_en, rx_wr_en;
  logic [BYTE_W-1:0] tx_rd_r, rx_rd_r;

  logic           pend_r;
  uartrb_status_t pend_stat_r, stat_nxt;
  logic           out_valid_r;
  uartrb_status_t out_stat_r;
  logic [BYTE_W-1:0] out_read_byte_r, out_send_byte_r;

  logic          in_fire, move;
  uartrb_op_t    op;
  logic [31:0]   tx_fill_ext, rx_fill_ext;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : idx + AW'(1);
  endfunction

  assign move     = pend_r && (!out_valid_r || out_ready);
  assign in_ready = !pend_r || move;
  assign in_fire  = in_valid && in_ready;
  assign op       = uartrb_op_t'(in_operation);

  always_comb begin
    tx_put_nxt  = tx_put_r;
    tx_take_nxt = tx_take_r;
    tx_fill_nxt = tx_fill_r;
    rx_put_nxt  = rx_put_r;
    rx_take_nxt = rx_take_r;
    rx_fill_nxt = rx_fill_r;
    tx_irq_nxt  = tx_irq_r;
    tx_wr_en    = 1'b0;
    rx_wr_en    = 1'b0;
    stat_nxt    = '0;
    unique case (op)
      OP_WRITE: begin
        if (tx_fill_r != FULL_FILL) begin
          tx_wr_en                = 1'b1;
          tx_put_nxt              = next_slot(tx_put_r);
          tx_fill_nxt             = tx_fill_r + FW'(1);
          tx_irq_nxt              = 1'b1;
          stat_nxt.write_accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (rx_fill_r != '0) begin
          rx_take_nxt         = next_slot(rx_take_r);
          rx_fill_nxt         = rx_fill_r - FW'(1);
          stat_nxt.read_valid = 1'b1;
        end
      end
      OP_EVENT: begin
        if (in_rx_ready) begin
          if (rx_fill_r != FULL_FILL) begin
            rx_wr_en    = 1'b1;
            rx_put_nxt  = next_slot(rx_put_r);
            rx_fill_nxt = rx_fill_r + FW'(1);
          end else begin
            stat_nxt.rx_dropped = 1'b1;
          end
        end
        if (in_tx_empty && tx_irq_r) begin
          if (tx_fill_r != '0) begin
            tx_take_nxt         = next_slot(tx_take_r);
            tx_fill_nxt         = tx_fill_r - FW'(1);
            stat_nxt.send_valid = 1'b1;
          end else begin
            tx_irq_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    tx_fill_ext           = 32'(tx_fill_nxt);
    rx_fill_ext           = 32'(rx_fill_nxt);
    stat_nxt.tx_irq_on    = tx_irq_nxt;
    stat_nxt.rx_available = (rx_fill_nxt != '0);
    stat_nxt.tx_level     = tx_fill_ext[LEVEL_W-1:0];
    stat_nxt.rx_level     = rx_fill_ext[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_rd_r <= tx_mem[tx_take_r];
      rx_rd_r <= rx_mem[rx_take_r];
      if (tx_wr_en) begin
        tx_mem[tx_put_r] <= in_write_byte;
      end
      if (rx_wr_en) begin
        rx_mem[rx_put_r] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_put_r  <= '0;
      tx_take_r <= '0;
      tx_fill_r <= '0;
      rx_put_r  <= '0;
      rx_take_r <= '0;
      rx_fill_r <= '0;
      tx_irq_r  <= 1'b0;
    end else if (in_fire) begin
      tx_put_r  <= tx_put_nxt;
      tx_take_r <= tx_take_nxt;
      tx_fill_r <= tx_fill_nxt;
      rx_put_r  <= rx_put_nxt;
      rx_take_r <= rx_take_nxt;
      rx_fill_r <= rx_fill_nxt;
      tx_irq_r  <= tx_irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_stat_r <= stat_nxt;
    end
    if (move) begin
      out_stat_r      <= pend_stat_r;
      out_read_byte_r <= pend_stat_r.read_valid ? rx_rd_r : '0;
      out_send_byte_r <= pend_stat_r.send_valid ? tx_rd_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_accepted = out_stat_r.write_accepted;
  assign out_read_valid     = out_stat_r.read_valid;
  assign out_read_byte      = out_read_byte_r;
  assign out_send_valid     = out_stat_r.send_valid;
  assign out_send_byte      = out_send_byte_r;
  assign out_rx_dropped     = out_stat_r.rx_dropped;
  assign out_tx_irq_on      = out_stat_r.tx_irq_on;
  assign out_rx_available   = out_stat_r.rx_available;
  assign out_tx_level       = out_stat_r.tx_level;
  assign out_rx_level       = out_stat_r.rx_level;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_fill_r <= FULL_FILL) && (rx_fill_r <= FULL_FILL))
    else $error("ring fill count beyond depth");

  a_tx_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_fill_r == '0) |-> (tx_put_r == tx_take_r))
    else $error("transmit ring empty with pointers apart");

  a_rx_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_fill_r == '0) |-> (rx_put_r == rx_take_r))
    else $error("receive ring empty with pointers apart");

  a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !move) |=> pend_r)
    else $error("pending transaction lost");

endmodule
